/* src/cfr_pkg.sv */
// Package for the CRC-18 frame reassembler: payload structs, result codes,
// CRC constants and the byte-wide CRC step. No dependencies.
`default_nettype none

package cfr_pkg;

    localparam int CRC_W = 18;
    localparam logic [CRC_W-1:0] CRC_INIT = 18'h3FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 18'h23979;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_COMPLETE = 3'd1,
        ST_SEQ_ERR  = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_OVERFLOW = 3'd4,
        ST_CRC_ERR  = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0]       seq_num;
        logic [3:0]       byte_len;
        logic [63:0]      data_bytes;
        logic             is_last;
        logic [CRC_W-1:0] frame_crc;
    } t_frame;

    typedef struct packed {
        t_status     status;
        logic [6:0]  msg_length;
        logic [63:0] chunk;
        logic [3:0]  chunk_bytes;
        logic        last;
    } t_result;

    // Commands from the sequencer to the CRC unit.
    typedef struct packed {
        logic       init;
        logic       step;
        logic [7:0] data_byte;
    } t_crc_ctl;

    // One byte folded into the CRC, most significant bit first.
    function automatic logic [CRC_W-1:0] crc18_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 10'b0};
        for (int i = 0; i < 8; i++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* src/cfr_if.sv */
// Valid/ready channel interfaces for frames in and results out.
// Depends on cfr_pkg for the payload structs.
`default_nettype none

interface cfr_frame_if import cfr_pkg::*; ();
    logic   valid;
    logic   ready;
    t_frame data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cfr_result_if import cfr_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/cfr_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* src/cfr_crc_unit.sv */
// Shared CRC-18 accumulator that folds in one byte per cycle on command.
// Depends on cfr_pkg.
`default_nettype none

module cfr_crc_unit import cfr_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_crc_ctl         i_ctl,
    output logic      [CRC_W-1:0] o_crc
);

    logic [CRC_W-1:0] r_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            r_crc <= CRC_INIT;
        end else if (i_ctl.step) begin
            r_crc <= crc18_byte(r_crc, i_ctl.data_byte);
        end
    end

    assign o_crc = r_crc;

endmodule

`default_nettype wire

/* src/crc18_frame_reassembler.sv */
// Top level of the CRC-18 frame reassembler: sequencer, message store and
// output register. Depends on cfr_pkg, cfr_if, cfr_ram and cfr_crc_unit.
`default_nettype none

// The block takes one received frame per item and reassembles a message of up
// to MAX_MSG_BYTES bytes. Each frame is checked against the expected sequence
// number, its length and the room left in the store; a rejected frame yields a
// single result item with an error status and clears the decoder, although a
// mismatched frame numbered zero simply starts a new message. Accepted bytes
// are written to the message store one per cycle while the shared CRC unit
// folds the same byte into the CRC-18. When the last frame's CRC matches, the
// message is read back from the store, one byte per cycle through its single
// read port, and delivered as items of up to eight bytes. A frame that is not
// the last passes through S_DECIDE, S_WRITE and S_EMIT before the block is
// ready again; a completing frame passes through S_CHECK and then through
// S_CHUNK, S_READ, S_DRAIN and S_EMIT once per chunk. S_EMIT waits while the
// output register still holds an item that is not being read. The block
// accepts a new frame while an earlier result still waits in the output
// register.
module crc18_frame_reassembler import cfr_pkg::*; #(
    parameter int MAX_MSG_BYTES = 64,
    parameter int FRAME_BYTES   = 8
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    cfr_frame_if.sink   i_frame,
    cfr_result_if.source o_result
);

    localparam int CNT_W  = $clog2(MAX_MSG_BYTES + 1);
    localparam int ADDR_W = $clog2(MAX_MSG_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_WRITE,
        S_CHECK,
        S_CHUNK,
        S_READ,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state             r_state,     n_state;
    t_frame             r_frame,     n_frame;
    logic [2:0]         r_idx,       n_idx;
    logic [CNT_W-1:0]   r_count,     n_count;
    logic [7:0]         r_exp_seq,   n_exp_seq;
    logic [CNT_W-1:0]   r_pos,       n_pos;
    logic [2:0]         r_issue,     n_issue;
    logic               r_rd_v,      n_rd_v;
    logic [2:0]         r_rd_lane,   n_rd_lane;
    logic [63:0]        r_word,      n_word;
    t_status            r_status,    n_status;
    logic [3:0]         r_cbytes,    n_cbytes;
    logic               r_last,      n_last;
    t_result            r_out,       n_out;
    logic               r_out_valid, n_out_valid;

    t_crc_ctl           crc_ctl;
    logic [CRC_W-1:0]   crc_value;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [7:0]         ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [7:0]         ram_rdata;

    logic               seq_mis;
    logic [CNT_W-1:0]   base_count;
    logic [CNT_W:0]     sum_count;
    logic [CNT_W-1:0]   remaining;
    logic [7:0]         cur_byte;

    cfr_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crc_ctl),
        .o_crc   (crc_value)
    );

    cfr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_MSG_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_frame.ready  = (r_state == S_IDLE);
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    // Frame checks. A sequence mismatch restarts the count from zero, so the
    // overflow check is made against the count that will actually apply.
    assign seq_mis    = (r_frame.seq_num != r_exp_seq);
    assign base_count = seq_mis ? '0 : r_count;
    assign sum_count  = {1'b0, base_count} + (CNT_W+1)'(r_frame.byte_len);
    assign remaining  = r_count - r_pos;
    assign cur_byte   = r_frame.data_bytes[{r_idx, 3'b000} +: 8];

    always_comb begin
        n_state     = r_state;
        n_frame     = r_frame;
        n_idx       = r_idx;
        n_count     = r_count;
        n_exp_seq   = r_exp_seq;
        n_pos       = r_pos;
        n_issue     = r_issue;
        n_rd_v      = 1'b0;
        n_rd_lane   = r_issue;
        n_word      = r_word;
        n_status    = r_status;
        n_cbytes    = r_cbytes;
        n_last      = r_last;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        crc_ctl     = '0;
        ram_we      = 1'b0;
        ram_waddr   = r_count[ADDR_W-1:0];
        ram_wdata   = cur_byte;
        ram_raddr   = ADDR_W'(r_pos + CNT_W'(r_issue));

        // A read issued last cycle lands in its byte lane of the chunk word.
        if (r_rd_v) begin
            n_word[{r_rd_lane, 3'b000} +: 8] = ram_rdata;
        end

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_frame.valid) begin
                    n_frame = i_frame.data;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_cbytes = '0;
                n_last   = 1'b1;
                n_word   = '0;
                if ((seq_mis && r_frame.seq_num != '0) || r_frame.byte_len == '0 ||
                    r_frame.byte_len > 4'(FRAME_BYTES) ||
                    sum_count > (CNT_W+1)'(MAX_MSG_BYTES)) begin
                    // Rejected frame: report it and clear the decoder.
                    if (seq_mis && r_frame.seq_num != '0) begin
                        n_status = ST_SEQ_ERR;
                    end else if (r_frame.byte_len == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_status = ST_OVERFLOW;
                    end
                    n_count      = '0;
                    n_exp_seq    = '0;
                    crc_ctl.init = 1'b1;
                    n_state      = S_EMIT;
                end else begin
                    if (seq_mis) begin
                        n_exp_seq    = '0;
                        crc_ctl.init = 1'b1;
                    end
                    n_count = base_count;
                    n_idx   = '0;
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                ram_we            = 1'b1;
                crc_ctl.step      = 1'b1;
                crc_ctl.data_byte = cur_byte;
                n_count           = r_count + CNT_W'(1);
                n_idx             = r_idx + 3'd1;
                if ({1'b0, r_idx} == r_frame.byte_len - 4'd1) begin
                    n_exp_seq = r_exp_seq + 8'd1;
                    if (r_frame.is_last) begin
                        n_state = S_CHECK;
                    end else begin
                        n_status = ST_ACCEPTED;
                        n_state  = S_EMIT;
                    end
                end
            end
            S_CHECK: begin
                if (crc_value != r_frame.frame_crc) begin
                    n_status     = ST_CRC_ERR;
                    n_count      = '0;
                    n_exp_seq    = '0;
                    crc_ctl.init = 1'b1;
                    n_state      = S_EMIT;
                end else begin
                    n_pos   = '0;
                    n_state = S_CHUNK;
                end
            end
            S_CHUNK: begin
                n_status = ST_COMPLETE;
                n_last   = (remaining <= CNT_W'(8));
                n_cbytes = (remaining <= CNT_W'(8)) ? 4'(remaining) : 4'd8;
                n_word   = '0;
                n_issue  = '0;
                n_state  = S_READ;
            end
            S_READ: begin
                n_rd_v  = 1'b1;
                n_issue = r_issue + 3'd1;
                if ({1'b0, r_issue} == r_cbytes - 4'd1) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out.status      = r_status;
                    n_out.msg_length  = (r_status == ST_COMPLETE) ? 7'(r_count) : 7'd0;
                    n_out.chunk       = r_word;
                    n_out.chunk_bytes = r_cbytes;
                    n_out.last        = r_last;
                    n_out_valid       = 1'b1;
                    if (r_status == ST_COMPLETE && !r_last) begin
                        n_pos   = r_pos + CNT_W'(8);
                        n_state = S_CHUNK;
                    end else begin
                        if (r_status == ST_COMPLETE) begin
                            // Whole message delivered: start afresh.
                            n_count      = '0;
                            n_exp_seq    = '0;
                            crc_ctl.init = 1'b1;
                        end
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_exp_seq   <= '0;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_exp_seq   <= n_exp_seq;
            r_rd_v      <= n_rd_v;
            r_out_valid <= n_out_valid;
        end
        r_frame   <= n_frame;
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_issue   <= n_issue;
        r_rd_lane <= n_rd_lane;
        r_word    <= n_word;
        r_status  <= n_status;
        r_cbytes  <= n_cbytes;
        r_last    <= n_last;
        r_out     <= n_out;
    end

`ifndef SYNTHESIS
    // The store count can never pass the store size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_MSG_BYTES))
        else $error("stored byte count exceeds the message store");

    // A completed-message item carries between one and eight bytes.
    a_chunk_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == ST_COMPLETE |->
            r_out.chunk_bytes != 4'd0 && r_out.chunk_bytes <= 4'd8)
        else $error("completed chunk has an invalid byte count");

    // Any other status is a single, empty, final item.
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != ST_COMPLETE |->
            r_out.last && r_out.chunk == '0 && r_out.msg_length == '0)
        else $error("status item carries message data");

    // In the cycle after a frame is taken the block is not ready for another.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frame.valid && i_frame.ready |=> !i_frame.ready)
        else $error("frame accepted while the previous one is being decoded");
`endif

endmodule

`default_nettype wire
